// ----- hdl/cbs_pkg.sv -----
// cbs_pkg: shared constants and types for the bounding sphere block
// no dependencies
package cbs_pkg;
  localparam int CoordBits = 24;
  localparam int MaxVertices = 1024;
  localparam int AddrBits = $clog2(MaxVertices);
  localparam int CountBits = AddrBits + 1;
  localparam int SumBits = CoordBits + CountBits;
  localparam int DiffBits = CoordBits + 2;
  localparam int DistBits = 2 * DiffBits + 2;
  localparam int RadiusBits = CoordBits + 1;
  localparam int RootBits = DistBits / 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [SumBits-1:0] sum_t;

  typedef struct packed {
    logic start;
    logic [SumBits-1:0] dividend;
    logic [CountBits-1:0] divisor;
  } div_req_t;
endpackage

// ----- hdl/centroid_bounding_sphere.sv -----
// centroid_bounding_sphere: centroid and bounding radius of a vertex group
// vertex beats load at one per cycle; after a last beat stall_o stays high while the three
// centroid divides run on the shared divider, each vertex passes the shared squarer axis by
// axis, and the square root runs; valid_o then rises, and input reopens after the result beat
// reset is asynchronous active low and clears sums, count, overflow flag and valid_o
// depends on cbs_pkg, cbs_divider, cbs_isqrt
module centroid_bounding_sphere (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  cbs_pkg::coord_t vert_x_i,
  input  cbs_pkg::coord_t vert_y_i,
  input  cbs_pkg::coord_t vert_z_i,
  input  logic last_vertex_i,
  output logic valid_o,
  input  logic stall_i,
  output cbs_pkg::coord_t center_x_o,
  output cbs_pkg::coord_t center_y_o,
  output cbs_pkg::coord_t center_z_o,
  output logic [cbs_pkg::RadiusBits-1:0] radius_o,
  output logic overflowed_o
);
  localparam int CB = cbs_pkg::CoordBits;
  localparam int DFB = cbs_pkg::DiffBits;
  localparam int DSB = cbs_pkg::DistBits;

  typedef enum logic [3:0] {
    S_LOAD, S_DIV_START, S_DIV_WAIT, S_RD, S_SQ, S_ACC, S_SQRT_START, S_SQRT_WAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [3*CB-1:0] mem [cbs_pkg::MaxVertices];
  logic [3*CB-1:0] rd_q;
  cbs_pkg::sum_t sum_q [3];
  cbs_pkg::coord_t cen_q [3];
  logic [cbs_pkg::CountBits-1:0] count_q, idx_q;
  logic [1:0] axis_q;
  logic ovf_q;
  logic [DSB-1:0] acc_q, max_q;
  logic [2*DFB-1:0] sq_q;
  logic signed [DFB-1:0] diff;
  logic [DFB-1:0] absd;
  logic accept, full;
  cbs_pkg::div_req_t dreq;
  logic dbusy, sstart, sbusy;
  cbs_pkg::coord_t dquot;
  logic [cbs_pkg::RadiusBits-1:0] root;
  logic [DSB-1:0] acc_new;

  assign accept = valid_i && !stall_o;
  assign full = (count_q == cbs_pkg::CountBits'(cbs_pkg::MaxVertices));
  assign stall_o = (state_q != S_LOAD);

  // shared divider for the three centroid axes
  assign dreq.start = (state_q == S_DIV_START);
  assign dreq.dividend = sum_q[axis_q];
  assign dreq.divisor = count_q;

  cbs_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .busy_o(dbusy), .quot_o(dquot));

  assign sstart = (state_q == S_SQRT_START);
  cbs_isqrt u_sqrt (.clk_i, .rst_ni, .start_i(sstart), .value_i(max_q),
                    .busy_o(sbusy), .root_o(root));

  // one axis difference at a time into the shared squarer
  always_comb begin
    case (axis_q)
      2'd0: diff = DFB'(signed'(rd_q[CB-1:0])) - DFB'(cen_q[0]);
      2'd1: diff = DFB'(signed'(rd_q[2*CB-1:CB])) - DFB'(cen_q[1]);
      default: diff = DFB'(signed'(rd_q[3*CB-1:2*CB])) - DFB'(cen_q[2]);
    endcase
    absd = diff[DFB-1] ? DFB'(-diff) : diff;
    acc_new = acc_q + DSB'(sq_q);
  end

  // vertex store
  always_ff @(posedge clk_i) begin
    if (accept && !full) mem[count_q[cbs_pkg::AddrBits-1:0]] <=
        {vert_z_i, vert_y_i, vert_x_i};
    rd_q <= mem[idx_q[cbs_pkg::AddrBits-1:0]];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      ovf_q <= 1'b0;
      valid_o <= 1'b0;
      axis_q <= '0;
      idx_q <= '0;
      acc_q <= '0;
      max_q <= '0;
      sq_q <= '0;
      center_x_o <= '0;
      center_y_o <= '0;
      center_z_o <= '0;
      radius_o <= '0;
      overflowed_o <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
        cen_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_LOAD: if (accept) begin
          if (!full) begin
            count_q <= count_q + 1'b1;
            sum_q[0] <= sum_q[0] + cbs_pkg::SumBits'(vert_x_i);
            sum_q[1] <= sum_q[1] + cbs_pkg::SumBits'(vert_y_i);
            sum_q[2] <= sum_q[2] + cbs_pkg::SumBits'(vert_z_i);
          end else ovf_q <= 1'b1;
          if (last_vertex_i) begin
            axis_q <= '0;
            state_q <= S_DIV_START;
          end
        end
        S_DIV_START: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: if (!dbusy) begin
          cen_q[axis_q] <= dquot;
          if (axis_q == 2'd2) begin
            idx_q <= '0;
            max_q <= '0;
            state_q <= S_RD;
          end else begin
            axis_q <= axis_q + 1'b1;
            state_q <= S_DIV_START;
          end
        end
        S_RD: begin
          axis_q <= '0;
          acc_q <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          sq_q <= absd * absd;
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (axis_q == 2'd2) begin
            if (acc_new > max_q) max_q <= acc_new;
            if (idx_q + 1'b1 == count_q) state_q <= S_SQRT_START;
            else state_q <= S_RD;
            idx_q <= idx_q + 1'b1;
          end else begin
            acc_q <= acc_new;
            axis_q <= axis_q + 1'b1;
            state_q <= S_SQ;
          end
        end
        S_SQRT_START: state_q <= S_SQRT_WAIT;
        S_SQRT_WAIT: if (!sbusy) begin
          center_x_o <= cen_q[0];
          center_y_o <= cen_q[1];
          center_z_o <= cen_q[2];
          radius_o <= root;
          overflowed_o <= ovf_q;
          valid_o <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: if (!stall_i) begin
          valid_o <= 1'b0;
          count_q <= '0;
          ovf_q <= 1'b0;
          for (int i = 0; i < 3; i++) sum_q[i] <= '0;
          state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule

// ----- hdl/cbs_divider.sv -----
// cbs_divider: restoring divider, one quotient bit per cycle, truncates toward zero
// depends on cbs_pkg
module cbs_divider (
  input  logic clk_i,
  input  logic rst_ni,
  input  cbs_pkg::div_req_t req_i,
  output logic busy_o,
  output cbs_pkg::coord_t quot_o
);
  localparam int SB = cbs_pkg::SumBits;
  logic [SB-1:0] mag_q, mag_d, quo_q, quo_d;
  logic [SB-1:0] rem_q, rem_d;
  logic [cbs_pkg::CountBits-1:0] den_q;
  logic neg_q;
  logic [$clog2(SB+1)-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [SB:0] trial;
  logic [SB-1:0] q_signed;

  // one shift-subtract step
  always_comb begin
    trial = {rem_q, mag_q[SB-1]};
    mag_d = mag_q << 1;
    quo_d = quo_q << 1;
    rem_d = trial[SB-1:0];
    if (trial >= {{(SB+1-cbs_pkg::CountBits){1'b0}}, den_q}) begin
      rem_d = SB'(trial - {{(SB+1-cbs_pkg::CountBits){1'b0}}, den_q});
      quo_d[0] = 1'b1;
    end
    cnt_d = cnt_q - 1'b1;
    busy_d = (cnt_q != 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q <= ($clog2(SB+1))'(SB);
    end else if (busy_q) begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[SB-1];
      mag_q <= req_i.dividend[SB-1] ? SB'(-req_i.dividend) : req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      mag_q <= mag_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign q_signed = neg_q ? SB'(-quo_q) : quo_q;
  assign quot_o = q_signed[cbs_pkg::CoordBits-1:0];
  assign busy_o = busy_q;
endmodule

// ----- hdl/cbs_isqrt.sv -----
// cbs_isqrt: bit-pair integer square root, one root bit per cycle
// depends on cbs_pkg
module cbs_isqrt (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [cbs_pkg::DistBits-1:0] value_i,
  output logic busy_o,
  output logic [cbs_pkg::RadiusBits-1:0] root_o
);
  localparam int DB = cbs_pkg::DistBits;
  localparam int RB = cbs_pkg::RootBits;
  logic [DB-1:0] val_q;
  logic [RB+1:0] rem_q, rem_d;
  logic [RB-1:0] root_q, root_d;
  logic [$clog2(RB+1)-1:0] cnt_q;
  logic busy_q;
  logic [RB+1:0] cur, trial;

  // one digit step
  always_comb begin
    cur = {rem_q[RB-1:0], val_q[DB-1:DB-2]};
    trial = {root_q, 2'b01};
    rem_d = cur;
    root_d = {root_q[RB-2:0], 1'b0};
    if (cur >= trial) begin
      rem_d = cur - trial;
      root_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= ($clog2(RB+1))'(RB);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      busy_q <= (cnt_q != 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      rem_q <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= val_q << 2;
      rem_q <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q[cbs_pkg::RadiusBits-1:0];
  assign busy_o = busy_q;
endmodule
